@@ design/rsf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared codes and word types for the render state filter.
// ----------------------------------------------------------------------------
package rsf_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int CMD_WIDTH   = 3;
  localparam int OP_WIDTH    = 3;

  // input command codes
  localparam logic [CMD_WIDTH-1:0] CMD_MATERIAL    = 3'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_DRAW        = 3'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_MOVE        = 3'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_ROTATE      = 3'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_CAMERA      = 3'd4;
  localparam logic [CMD_WIDTH-1:0] CMD_PROXY_BEGIN = 3'd5;
  localparam logic [CMD_WIDTH-1:0] CMD_PROXY_END   = 3'd6;
  localparam logic [CMD_WIDTH-1:0] CMD_IGNORED     = 3'd7;

  // result op codes
  localparam logic [OP_WIDTH-1:0] OP_MATERIAL    = 3'd0;
  localparam logic [OP_WIDTH-1:0] OP_BUFFER_BIND = 3'd1;
  localparam logic [OP_WIDTH-1:0] OP_DRAW        = 3'd2;
  localparam logic [OP_WIDTH-1:0] OP_MOVE        = 3'd3;
  localparam logic [OP_WIDTH-1:0] OP_ROTATE      = 3'd4;
  localparam logic [OP_WIDTH-1:0] OP_CAMERA      = 3'd5;
  localparam logic [OP_WIDTH-1:0] OP_PROXY_BEGIN = 3'd6;
  localparam logic [OP_WIDTH-1:0] OP_PROXY_END   = 3'd7;

  // result queue
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CMD_WIDTH-1:0]          cmd;
    logic [FIELD_WIDTH-1:0]        handle;
    logic [FIELD_WIDTH-1:0]        aux_handle;
    logic signed [FIELD_WIDTH-1:0] x_in;
    logic signed [FIELD_WIDTH-1:0] y_in;
    logic signed [FIELD_WIDTH-1:0] z_in;
    logic signed [FIELD_WIDTH-1:0] w_in;
  } cmd_word_t;

  // one queued record; dual marks a draw preceded by a buffer bind
  typedef struct packed {
    logic [OP_WIDTH-1:0]           op;
    logic [FIELD_WIDTH-1:0]        handle;
    logic [FIELD_WIDTH-1:0]        aux_handle;
    logic signed [FIELD_WIDTH-1:0] dx;
    logic signed [FIELD_WIDTH-1:0] dy;
    logic signed [FIELD_WIDTH-1:0] dz;
    logic signed [FIELD_WIDTH-1:0] dw;
    logic                          dual;
  } result_rec_t;

endpackage

@@ design/rsf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_in_if
// Command word channel: valid/ready plus command payload.
// ----------------------------------------------------------------------------
interface rsf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] handle;
  logic [31:0] aux_handle;
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  logic signed [31:0] z_in;
  logic signed [31:0] w_in;

  modport source (
    output valid, cmd, handle, aux_handle, x_in, y_in, z_in, w_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, handle, aux_handle, x_in, y_in, z_in, w_in,
    output ready
  );
endinterface

@@ design/rsf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_out_if
// Result word channel: valid/ready plus filtered command payload.
// ----------------------------------------------------------------------------
interface rsf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_op;
  logic [31:0] out_handle;
  logic [31:0] out_aux_handle;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] dz;
  logic signed [31:0] dw;
  logic        last;

  modport source (
    output valid, out_op, out_handle, out_aux_handle, dx, dy, dz, dw, last,
    input  ready
  );
  modport sink (
    input  valid, out_op, out_handle, out_aux_handle, dx, dy, dz, dw, last,
    output ready
  );
endinterface

@@ design/render_state_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// render_state_filter
// Drops redundant material/buffer binds and unchanged moves/rotates from a
// render command stream; moves and rotates go out as wrapping deltas.
// ----------------------------------------------------------------------------
// Output: a taken word's record, if any, is registered in the result queue.
// Throughput: one command word per cycle while the queue has room; a draw that
//   changes the buffer puts out two words (bind, draw) from one queue entry.
// Input ready drops only while the two-entry result queue is full.
// Reset (rst, sync) zeroes material, buffer, position, rotation and the queue.
// ----------------------------------------------------------------------------
module render_state_filter #(
  parameter int COORD_WIDTH  = 32,  // internal width of position/rotation
  parameter int HANDLE_WIDTH = 32   // stored handle width
) (
  input  logic      clk,
  input  logic      rst,
  rsf_in_if.sink    cmds,
  rsf_out_if.source results
);

  // Command side: a word is taken whenever the queue has a free slot, so a
  // new word can enter while an earlier result still waits downstream.
  logic                 accept;
  logic                 push;
  logic                 full;
  rsf_pkg::cmd_word_t   word;
  rsf_pkg::result_rec_t rec;

  assign cmds.ready = ~full;
  assign accept     = cmds.valid & cmds.ready;

  assign word.cmd        = cmds.cmd;
  assign word.handle     = cmds.handle;
  assign word.aux_handle = cmds.aux_handle;
  assign word.x_in       = cmds.x_in;
  assign word.y_in       = cmds.y_in;
  assign word.z_in       = cmds.z_in;
  assign word.w_in       = cmds.w_in;

  // State compare/subtract and record build; one record per taken word at
  // most (a draw with a new buffer is a single record marked dual).
  rsf_core #(
    .COORD_WIDTH  (COORD_WIDTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word   (word),
    .push   (push),
    .rec    (rec)
  );

  // Result register stage: holds records and splits dual ones into the
  // buffer bind word (last low) followed by the draw word (last high).
  rsf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rec     (rec),
    .full    (full),
    .results (results)
  );

endmodule

@@ design/rsf_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_core
// Holds bind/transform state and builds at most one result record per command word.
// ----------------------------------------------------------------------------
module rsf_core #(
  parameter int COORD_WIDTH  = 32,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  rsf_pkg::cmd_word_t   word,
  output logic                 push,
  output rsf_pkg::result_rec_t rec
);

  logic [HANDLE_WIDTH-1:0] active_material, active_material_next;
  logic [HANDLE_WIDTH-1:0] active_buffer, active_buffer_next;
  logic [COORD_WIDTH-1:0]  position [3];
  logic [COORD_WIDTH-1:0]  position_next [3];
  logic [COORD_WIDTH-1:0]  rotation [4];
  logic [COORD_WIDTH-1:0]  rotation_next [4];

  logic [HANDLE_WIDTH-1:0] h_in, a_in;
  logic [COORD_WIDTH-1:0]  c_in [4];
  logic [COORD_WIDTH-1:0]  d_pos [3];
  logic [COORD_WIDTH-1:0]  d_rot [4];
  logic                    move_diff, rot_diff;
  logic                    produce;

  assign h_in    = HANDLE_WIDTH'(word.handle);
  assign a_in    = HANDLE_WIDTH'(word.aux_handle);
  // sign-extend (or truncate) Q16.16 fields to the coordinate width
  assign c_in[0] = COORD_WIDTH'(word.x_in);
  assign c_in[1] = COORD_WIDTH'(word.y_in);
  assign c_in[2] = COORD_WIDTH'(word.z_in);
  assign c_in[3] = COORD_WIDTH'(word.w_in);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_pos[i] = c_in[i] - position[i];
    end
    for (int i = 0; i < 4; i++) begin
      d_rot[i] = c_in[i] - rotation[i];
    end
  end

  assign move_diff = (c_in[0] != position[0]) | (c_in[1] != position[1]) |
                     (c_in[2] != position[2]);
  assign rot_diff  = move_diff ? ((c_in[0] != rotation[0]) | (c_in[1] != rotation[1]) |
                                  (c_in[2] != rotation[2]) | (c_in[3] != rotation[3]))
                               : ((c_in[0] != rotation[0]) | (c_in[1] != rotation[1]) |
                                  (c_in[2] != rotation[2]) | (c_in[3] != rotation[3]));

  always_comb begin
    produce              = 1'b0;
    rec                  = '0;
    active_material_next = active_material;
    active_buffer_next   = active_buffer;
    position_next        = position;
    rotation_next        = rotation;
    unique case (word.cmd)
      rsf_pkg::CMD_MATERIAL: begin
        rec.op     = rsf_pkg::OP_MATERIAL;
        rec.handle = rsf_pkg::FIELD_WIDTH'(h_in);
        produce    = (h_in != active_material);
        active_material_next = h_in;
      end
      rsf_pkg::CMD_DRAW: begin
        rec.op     = rsf_pkg::OP_DRAW;
        rec.handle = rsf_pkg::FIELD_WIDTH'(h_in);
        rec.dual   = (h_in != active_buffer);
        produce    = 1'b1;
        active_buffer_next = h_in;
      end
      rsf_pkg::CMD_MOVE: begin
        rec.op  = rsf_pkg::OP_MOVE;
        rec.dx  = rsf_pkg::FIELD_WIDTH'(d_pos[0]);
        rec.dy  = rsf_pkg::FIELD_WIDTH'(d_pos[1]);
        rec.dz  = rsf_pkg::FIELD_WIDTH'(d_pos[2]);
        produce = move_diff;
        for (int i = 0; i < 3; i++) begin
          position_next[i] = c_in[i];
        end
      end
      rsf_pkg::CMD_ROTATE: begin
        rec.op  = rsf_pkg::OP_ROTATE;
        rec.dx  = rsf_pkg::FIELD_WIDTH'(d_rot[0]);
        rec.dy  = rsf_pkg::FIELD_WIDTH'(d_rot[1]);
        rec.dz  = rsf_pkg::FIELD_WIDTH'(d_rot[2]);
        rec.dw  = rsf_pkg::FIELD_WIDTH'(d_rot[3]);
        produce = rot_diff;
        rotation_next = c_in;
      end
      rsf_pkg::CMD_CAMERA: begin
        rec.op  = rsf_pkg::OP_CAMERA;
        produce = 1'b1;
      end
      rsf_pkg::CMD_PROXY_BEGIN: begin
        rec.op         = rsf_pkg::OP_PROXY_BEGIN;
        rec.handle     = rsf_pkg::FIELD_WIDTH'(h_in);
        rec.aux_handle = rsf_pkg::FIELD_WIDTH'(a_in);
        produce        = 1'b1;
        for (int i = 0; i < 3; i++) begin
          position_next[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
          rotation_next[i] = '0;
        end
      end
      rsf_pkg::CMD_PROXY_END: begin
        rec.op  = rsf_pkg::OP_PROXY_END;
        produce = 1'b1;
      end
      rsf_pkg::CMD_IGNORED: begin
        produce = 1'b0;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  assign push = accept & produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_material <= '0;
      active_buffer   <= '0;
      for (int i = 0; i < 3; i++) begin
        position[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        rotation[i] <= '0;
      end
    end else if (accept) begin
      active_material <= active_material_next;
      active_buffer   <= active_buffer_next;
      position        <= position_next;
      rotation        <= rotation_next;
    end
  end

endmodule

@@ design/rsf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsf_queue
// Two-entry result queue; expands a dual record into buffer bind + draw.
// ----------------------------------------------------------------------------
module rsf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rsf_pkg::result_rec_t rec,
  output logic                 full,
  rsf_out_if.source            results
);

  rsf_pkg::result_rec_t entries [rsf_pkg::QUEUE_DEPTH];
  rsf_pkg::result_rec_t head;
  logic [rsf_pkg::QPTR_WIDTH-1:0]   wr_ptr, rd_ptr;
  logic [rsf_pkg::QCOUNT_WIDTH-1:0] count, count_next;
  logic second;      // bind word of the head already sent
  logic bind_phase;
  logic take, pop;

  assign head       = entries[rd_ptr];
  assign bind_phase = head.dual & ~second;
  assign full       = (count == rsf_pkg::QCOUNT_WIDTH'(rsf_pkg::QUEUE_DEPTH));

  assign results.valid          = (count != '0);
  assign results.out_op         = bind_phase ? rsf_pkg::OP_BUFFER_BIND : head.op;
  assign results.out_handle     = head.handle;
  assign results.out_aux_handle = head.aux_handle;
  assign results.dx             = head.dx;
  assign results.dy             = head.dy;
  assign results.dz             = head.dz;
  assign results.dw             = head.dw;
  assign results.last           = ~bind_phase;

  assign take = results.valid & results.ready;
  assign pop  = take & ~bind_phase;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      second <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (take) begin
        second <= bind_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= rec;
    end
  end

endmodule
